// ----- rtl/core/bdmp_pkg.sv -----
// shared types and constants for the button debounce and press detector
package bdmp_pkg;

   localparam int TICK_BITS = 17;
   localparam int CFG_BITS = 16;
   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
   localparam logic REST_LEVEL_RESET = 1'b1;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_DEBOUNCE  = 2'd0,
      CSR_MULTI_GAP = 2'd1,
      CSR_LONG_HOLD = 2'd2,
      CSR_REST      = 2'd3
   } csr_index_type;

   // event codes reported per beat
   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_LONG   = 2'd1,
      EV_SERIES = 2'd2
   } event_kind_type;

   // press timing phases
   typedef enum logic [2:0] {
      PH_PRESS   = 3'b001,
      PH_RELEASE = 3'b010,
      PH_MULTI   = 3'b100
   } phase_type;

   typedef struct packed {
      logic           released_pulse;
      event_kind_type event_kind;
      logic [7:0]     press_total;
   } press_event_type;

   function automatic logic [TICK_BITS-1:0] tick_sat_inc(input logic [TICK_BITS-1:0] v);
      return (v == TICK_MAX) ? v : v + TICK_BITS'(1);
   endfunction

endpackage

// ----- rtl/core/button_debounce_multi_press.sv -----
// top level: button debounce with multi-press and long-press detection
//
//   channel | dir | ports                         | contents
//   req     | in  | req_tvalid/tready/tdata[7:0]  | raw_level in bit 0
//   rsp     | out | rsp_tvalid/tready/tdata[15:0] | clean, pressed, released, press_total
//           |     | rsp_tuser[1:0]                | event_kind
//   csr     | in  | csr_we/addr[1:0]/wdata[15:0]  | register writes, no read-back
//
// one beat per cycle while the output is not stalled: each accepted tick updates the debounce
// and phase state and loads its result into the output register in the same cycle
// a tick is taken whenever the output register is empty or is being drained
// reset is synchronous and clears all state but the output payload, registers return to their defaults
// a stalled output holds its beat and blocks further ticks until taken
module button_debounce_multi_press import bdmp_pkg::*; #(
   parameter int COUNT_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   // input ticks
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [0] raw_level, [7:1] zero
   // results
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // [0] clean_level, [1] pressed,
                                            // [2] released_pulse, [10:3] press_total
   output logic [1:0]          rsp_tuser,   // [1:0] event_kind
   // configuration
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   // configuration registers
   logic [CFG_BITS-1:0] debounce_ff, multi_gap_ff, long_hold_ff;
   logic                rest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= CFG_BITS'(50);
         multi_gap_ff <= CFG_BITS'(300);
         long_hold_ff <= CFG_BITS'(1000);
         rest_ff      <= REST_LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_DEBOUNCE:  debounce_ff  <= csr_wdata;
            CSR_MULTI_GAP: multi_gap_ff <= csr_wdata;
            CSR_LONG_HOLD: long_hold_ff <= csr_wdata;
            CSR_REST:      rest_ff      <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   // handshake: output register frees up when drained
   logic step;
   assign req_tready = !rsp_tvalid || rsp_tready;
   assign step       = req_tvalid && req_tready;

   // debounce stage
   logic clean_level, held;

   bdmp_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .raw_level      (req_tdata[0]),
      .debounce_ticks (debounce_ff),
      .clean_level    (clean_level)
   );

   // pressed when the clean level is away from rest
   assign held = (clean_level != rest_ff);

   // hold / gap timing
   press_event_type press_event;

   bdmp_press_fsm #(
      .COUNT_BITS (COUNT_BITS)
   ) u_press_fsm (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .held            (held),
      .multi_gap_ticks (multi_gap_ff),
      .long_hold_ticks (long_hold_ff),
      .press_event     (press_event)
   );

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   always_comb begin
      rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = {5'd0, press_event.press_total, press_event.released_pulse,
                      held, clean_level};
      rsp_user_in  = press_event.event_kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads only on an accepted tick
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // press count only travels with a series-end event
   a_total_only_series: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != EV_SERIES) |-> (rsp_tdata[10:3] == 8'd0))
      else $error("press_total nonzero without series event");

   // a release beat never shows the button still held
   a_release_not_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1])
      else $error("release pulse while pressed");

   // a long press is reported on the release tick
   a_long_with_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_LONG) |-> rsp_tdata[2])
      else $error("long press without release");

   // a stalled result blocks new ticks
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("tick accepted over a stalled result");

endmodule

// ----- rtl/core/bdmp_debounce.sv -----
// debounce filter: stability counter and filtered level
module bdmp_debounce import bdmp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                raw_level,
   input  logic [CFG_BITS-1:0] debounce_ticks,
   output logic                clean_level
);

   logic                 prior_raw_ff, prior_raw_in;
   logic [TICK_BITS-1:0] stable_ticks_ff, stable_ticks_in;
   logic                 filtered_ff, filtered_in;

   always_comb begin
      prior_raw_in = raw_level;
      if (raw_level != prior_raw_ff) begin
         stable_ticks_in = '0;
      end else begin
         stable_ticks_in = tick_sat_inc(stable_ticks_ff);
      end
      if (stable_ticks_in > TICK_BITS'(debounce_ticks)) begin
         filtered_in = raw_level;
      end else begin
         filtered_in = filtered_ff;
      end
   end

   // level after this tick
   assign clean_level = filtered_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_raw_ff    <= REST_LEVEL_RESET;
         stable_ticks_ff <= '0;
         filtered_ff     <= REST_LEVEL_RESET;
      end else if (step) begin
         prior_raw_ff    <= prior_raw_in;
         stable_ticks_ff <= stable_ticks_in;
         filtered_ff     <= filtered_in;
      end
   end

endmodule

// ----- rtl/core/bdmp_press_fsm.sv -----
// press timing: hold and gap timer, series counter, event decode
module bdmp_press_fsm import bdmp_pkg::*; #(
   parameter int COUNT_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                held,
   input  logic [CFG_BITS-1:0] multi_gap_ticks,
   input  logic [CFG_BITS-1:0] long_hold_ticks,
   output press_event_type     press_event
);

   localparam int ExtW = (COUNT_BITS > 8) ? COUNT_BITS : 8;

   phase_type             phase_ff, phase_in;
   logic [TICK_BITS-1:0]  phase_ticks_ff, phase_ticks_in, ticks_inc;
   logic [COUNT_BITS-1:0] series_ff, series_in;
   logic [ExtW-1:0]       series_ext;

   always_comb begin
      ticks_inc      = tick_sat_inc(phase_ticks_ff);
      phase_in       = phase_ff;
      phase_ticks_in = ticks_inc;
      series_in      = series_ff;
      series_ext     = ExtW'(series_ff);
      press_event    = '{released_pulse: 1'b0, event_kind: EV_NONE, press_total: 8'd0};
      case (phase_ff)
         PH_PRESS: begin
            series_in = '0;
            if (held) begin
               phase_in       = PH_RELEASE;
               phase_ticks_in = '0;
            end
         end
         PH_RELEASE: begin
            if (!held) begin
               press_event.released_pulse = 1'b1;
               if (ticks_inc > TICK_BITS'(long_hold_ticks)) begin
                  phase_in               = PH_PRESS;
                  series_in              = '0;
                  press_event.event_kind = EV_LONG;
               end else begin
                  if (series_ff != '1) begin
                     series_in = series_ff + COUNT_BITS'(1);
                  end
                  phase_in       = PH_MULTI;
                  phase_ticks_in = '0;
               end
            end
         end
         default: begin
            // waiting for a further press
            if (held) begin
               phase_in       = PH_RELEASE;
               phase_ticks_in = '0;
            end else if (ticks_inc > TICK_BITS'(multi_gap_ticks)) begin
               phase_in               = PH_PRESS;
               press_event.event_kind = EV_SERIES;
               press_event.press_total =
                  (series_ext > ExtW'(255)) ? 8'hFF : series_ext[7:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_PRESS;
         phase_ticks_ff <= '0;
         series_ff      <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         series_ff      <= series_in;
      end
   end

endmodule

// ----- sim/tb_button_debounce_multi_press.sv -----
// testbench for the button debounce and multi-press / long-press detector
module tb_button_debounce_multi_press;
   timeunit 1ns;
   timeprecision 1ps;
   import bdmp_pkg::*;

   localparam int COUNT_BITS = 8;
   localparam int PRESS_MAX = (1 << COUNT_BITS) - 1;
   localparam int IDLE_LIMIT = 5000;
   localparam int DIR_ROWS = 30;

   // register values after reset
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [15:0] MULTI_GAP_RESET = 16'd300;
   localparam logic [15:0] LONG_HOLD_RESET = 16'd1000;

   // one result beat, split into its fields
   typedef struct packed {
      logic           clean;
      logic           pressed;
      logic           released;
      event_kind_type kind;
      logic [7:0]     total;
   } tick_result_type;

   // one tick to send; typed ticks carry a hand-written expectation
   typedef struct packed {
      logic            raw;
      logic            typed;
      tick_result_type exp;
   } tick_item_type;

   typedef enum logic {
      ROW_TICK,
      ROW_WRITE
   } row_op_type;

   typedef struct packed {
      row_op_type      op;
      csr_index_type   sel;
      logic [15:0]     value;
      logic            typed;
      tick_result_type exp;
   } dir_row_type;

   // idle pin high, nothing pressed, nothing reported
   localparam tick_result_type QUIET_HIGH = '{1'b1, 1'b0, 1'b0, EV_NONE, 8'd0};
   localparam dir_row_type TICK_LO = '{ROW_TICK, CSR_DEBOUNCE, 16'd0, 1'b0, '0};
   localparam dir_row_type TICK_HI = '{ROW_TICK, CSR_DEBOUNCE, 16'd1, 1'b0, '0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [0] raw_level, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [0] clean, [1] pressed, [2] released, [10:3] total
   logic [1:0]  rsp_tuser;          // [1:0] event_kind
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = 2'd0;
   logic [15:0] csr_wdata = 16'd0;

   // travels alongside req_tdata so the monitor sees it at the accepting edge
   logic            tick_typed = 1'b0;
   tick_result_type tick_typed_exp = '0;

   button_debounce_multi_press #(
      .COUNT_BITS(COUNT_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // single synchronous reset at the start of the run
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // button model: shadow registers and state
   // ------------------------------------------------------------------
   logic [15:0]          debounce_lim;
   logic [15:0]          gap_lim;
   logic [15:0]          hold_lim;
   logic                 rest_lvl;
   logic                 last_raw;
   logic [TICK_BITS-1:0] stable_cnt;
   logic                 clean_lvl;
   phase_type            phase_now;
   logic [TICK_BITS-1:0] phase_cnt;
   int                   presses;

   tick_result_type tick_results_due[$];
   tick_item_type   tick_plan[$];
   int              mismatch_count = 0;
   int              burst_left = 0;

   // advance the button state by one tick and return what it reports
   task automatic step_button(input logic raw, output tick_result_type r);
      logic held;
      r = '0;
      // debounce: level must hold still longer than the limit
      if (raw != last_raw)
         stable_cnt = '0;
      else if (stable_cnt != TICK_MAX)
         stable_cnt = stable_cnt + 1'b1;
      if (stable_cnt > {1'b0, debounce_lim})
         clean_lvl = raw;
      last_raw = raw;
      held = (clean_lvl != rest_lvl);

      // press timing; any code other than the first two behaves as the gap phase
      if (phase_cnt != TICK_MAX)
         phase_cnt = phase_cnt + 1'b1;
      case (phase_now)
         PH_PRESS: begin
            presses = 0;
            if (held) begin
               phase_now = PH_RELEASE;
               phase_cnt = '0;
            end
         end
         PH_RELEASE: begin
            if (!held) begin
               r.released = 1'b1;
               if (phase_cnt > {1'b0, hold_lim}) begin
                  // long hold wipes the series
                  phase_now = PH_PRESS;
                  presses = 0;
                  r.kind = EV_LONG;
               end else begin
                  if (presses < PRESS_MAX)
                     presses++;
                  phase_now = PH_MULTI;
                  phase_cnt = '0;
               end
            end
         end
         default: begin
            if (held) begin
               phase_now = PH_RELEASE;
               phase_cnt = '0;
            end else if (phase_cnt > {1'b0, gap_lim}) begin
               phase_now = PH_PRESS;
               r.kind = EV_SERIES;
               r.total = (presses > 255) ? 8'd255 : 8'(presses);
            end
         end
      endcase
      r.clean = clean_lvl;
      r.pressed = held;
   endtask

   task automatic flag_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
      $display("%0t ns: %s expected %0d got %0d", $time, what, want_v, got_v);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // monitor: register writes, accepted ticks, returned beats
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      tick_result_type got;
      tick_result_type want;
      if (reset) begin
         debounce_lim = DEBOUNCE_RESET;
         gap_lim = MULTI_GAP_RESET;
         hold_lim = LONG_HOLD_RESET;
         rest_lvl = REST_LEVEL_RESET;
         last_raw = REST_LEVEL_RESET;
         stable_cnt = '0;
         clean_lvl = REST_LEVEL_RESET;
         phase_now = PH_PRESS;
         phase_cnt = '0;
         presses = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_DEBOUNCE:  debounce_lim = csr_wdata;
               CSR_MULTI_GAP: gap_lim = csr_wdata;
               CSR_LONG_HOLD: hold_lim = csr_wdata;
               CSR_REST:      rest_lvl = csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.clean = rsp_tdata[0];
            got.pressed = rsp_tdata[1];
            got.released = rsp_tdata[2];
            got.total = rsp_tdata[10:3];
            got.kind = event_kind_type'(rsp_tuser);
            if (tick_results_due.size() == 0) begin
               $display("%0t ns: beat with no tick waiting, expected none got tdata %h tuser %0d",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = tick_results_due.pop_front();
               if (got.clean !== want.clean)
                  flag_field("clean_level", 8'(want.clean), 8'(got.clean));
               if (got.pressed !== want.pressed)
                  flag_field("pressed", 8'(want.pressed), 8'(got.pressed));
               if (got.released !== want.released)
                  flag_field("released_pulse", 8'(want.released), 8'(got.released));
               if (got.kind !== want.kind)
                  flag_field("event_kind", 8'(want.kind), 8'(got.kind));
               if (got.total !== want.total)
                  flag_field("press_total", want.total, got.total);
               if (rsp_tdata[15:11] !== 5'd0)
                  flag_field("tdata pad", 8'd0, 8'(rsp_tdata[15:11]));
            end
         end

         if (req_tvalid && req_tready) begin
            step_button(req_tdata[0], want);
            if (tick_typed)
               want = tick_typed_exp;
            tick_results_due.push_back(want);
         end
      end
   end

   // receiver: rotates through always ready, random, fixed pattern and heavy stall
   logic [9:0] stall_phase = '0;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[8:7])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (stall_phase[2:0] != 3'd5) && (stall_phase[2:0] != 3'd6);
         default: rsp_tready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // watchdog: too long with no beat moving on either side
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("tb_button_debounce_multi_press NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------

   // send every planned tick, in bursts with gaps and the odd full drain
   task automatic play_ticks();
      int gap;
      tick_item_type item;
      if (tick_plan.size() != 0) begin
         while (tick_plan.size() != 0) begin
            item = tick_plan.pop_front();
            if (burst_left == 0) begin
               if ($urandom_range(0, 39) == 0) begin
                  // hold off until the block has returned everything
                  req_tvalid <= 1'b0;
                  @(posedge clock);
                  while (tick_results_due.size() != 0) @(posedge clock);
               end else begin
                  gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                  if (gap > 0) begin
                     req_tvalid <= 1'b0;
                     repeat (gap) @(posedge clock);
                  end
               end
               burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            end
            burst_left--;
            req_tvalid <= 1'b1;
            req_tdata <= {7'd0, item.raw};
            tick_typed <= item.typed;
            tick_typed_exp <= item.exp;
            @(posedge clock);
            while (!req_tready) @(posedge clock);
         end
         req_tvalid <= 1'b0;
      end
   endtask

   // registers change only with nothing in flight
   task automatic write_reg(input csr_index_type sel, input logic [15:0] value);
      @(posedge clock);
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // one setting of the registers, then presses with bounce, gaps and noise
   task automatic run_phase(input logic [15:0] deb, input logic [15:0] gap,
                            input logic [15:0] hold, input logic rest, input int n);
      int deb_cap;
      int gap_cap;
      int hold_cap;
      deb_cap = (deb > 20) ? 20 : int'(deb);
      gap_cap = (gap > 30) ? 30 : int'(gap);
      hold_cap = (hold > 30) ? 30 : int'(hold);
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_MULTI_GAP, gap);
      write_reg(CSR_LONG_HOLD, hold);
      write_reg(CSR_REST, {15'd0, rest});
      while (tick_plan.size() < n) begin
         if ($urandom_range(0, 4) == 0) begin
            // line noise
            repeat ($urandom_range(1, 6))
               tick_plan.push_back('{1'($urandom_range(0, 1)), 1'b0, '0});
         end else begin
            // contact bounce, then a hold, then bounce and a released gap
            repeat ($urandom_range(0, 2)) begin
               tick_plan.push_back('{~rest, 1'b0, '0});
               tick_plan.push_back('{rest, 1'b0, '0});
            end
            repeat (deb_cap + 1 + $urandom_range(0, hold_cap + 3))
               tick_plan.push_back('{~rest, 1'b0, '0});
            repeat ($urandom_range(0, 2)) begin
               tick_plan.push_back('{rest, 1'b0, '0});
               tick_plan.push_back('{~rest, 1'b0, '0});
            end
            repeat (deb_cap + 1 + $urandom_range(0, gap_cap + 4))
               tick_plan.push_back('{rest, 1'b0, '0});
         end
      end
      play_ticks();
   endtask

   dir_row_type dir_rows [DIR_ROWS];

   initial begin : stimulus
      logic rest;
      dir_rows = '{
         // straight after reset: defaults, a short glitch never gets through
         '{ROW_TICK, CSR_DEBOUNCE, 16'd1, 1'b1, QUIET_HIGH},
         '{ROW_TICK, CSR_DEBOUNCE, 16'd0, 1'b1, QUIET_HIGH},
         '{ROW_TICK, CSR_DEBOUNCE, 16'd1, 1'b1, QUIET_HIGH},
         // fastest debounce, tight gap and hold
         '{ROW_WRITE, CSR_DEBOUNCE, 16'd0, 1'b0, '0},
         '{ROW_WRITE, CSR_MULTI_GAP, 16'd1, 1'b0, '0},
         '{ROW_WRITE, CSR_LONG_HOLD, 16'd2, 1'b0, '0},
         '{ROW_WRITE, CSR_REST, 16'd1, 1'b0, '0},
         // long press: held past the limit, series dropped
         TICK_LO, TICK_LO, TICK_LO, TICK_LO, TICK_LO,
         TICK_HI, TICK_HI,
         // double press, then the gap ends the series
         TICK_LO, TICK_LO, TICK_HI, TICK_HI,
         TICK_LO, TICK_LO, TICK_HI, TICK_HI, TICK_HI, TICK_HI,
         // press held, then the rest level flips under it
         TICK_LO, TICK_LO,
         '{ROW_WRITE, CSR_REST, 16'd0, 1'b0, '0},
         TICK_LO,
         // slowest debounce
         '{ROW_WRITE, CSR_DEBOUNCE, 16'hFFFF, 1'b0, '0},
         TICK_HI
      };

      @(posedge clock);
      while (reset) @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].op == ROW_WRITE) begin
            play_ticks();
            write_reg(dir_rows[i].sel, dir_rows[i].value);
         end else begin
            tick_plan.push_back('{dir_rows[i].value[0], dir_rows[i].typed,
                                  dir_rows[i].exp});
         end
      end
      play_ticks();

      // register extremes, then random small settings
      run_phase(16'd0, 16'd0, 16'd0, 1'b0, 60);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 60);
      run_phase(16'd1, 16'hFFFF, 16'd12, 1'b0, 60);
      run_phase(16'd2, 16'd20, 16'hFFFF, 1'b1, 60);
      repeat (4)
         run_phase(16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
                   16'($urandom_range(0, 24)), 1'($urandom_range(0, 1)), 50);

      // one long series that runs the press count into its ceiling
      rest = 1'($urandom_range(0, 1));
      write_reg(CSR_DEBOUNCE, 16'd0);
      write_reg(CSR_MULTI_GAP, 16'd8);
      write_reg(CSR_LONG_HOLD, 16'd8);
      write_reg(CSR_REST, {15'd0, rest});
      repeat (PRESS_MAX + 7) begin
         repeat ($urandom_range(0, 5) == 0 ? 3 : 2)
            tick_plan.push_back('{~rest, 1'b0, '0});
         repeat ($urandom_range(0, 5) == 0 ? 3 : 2)
            tick_plan.push_back('{rest, 1'b0, '0});
      end
      repeat (12) tick_plan.push_back('{rest, 1'b0, '0});
      play_ticks();

      // drain, then wait on for anything stray before the verdict
      @(posedge clock);
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && tick_results_due.size() == 0)
         $display("tb_button_debounce_multi_press OK");
      else
         $display("tb_button_debounce_multi_press NOT OK");
      $finish;
   end

endmodule
